@@ design/fpr_pkg.sv @@
// Package for the FIFO page replacement core: widths, constants, the control
// state encoding and the per-cell control word.
// No dependencies.
`timescale 1ns / 1ps

package fpr_pkg;

   localparam int PAGE_W  = 8;
   localparam int CFG_W   = 5;
   localparam int TOTAL_W = 16;

   localparam logic [CFG_W-1:0]   CFG_RESET = 5'd16;
   localparam logic [TOTAL_W-1:0] TOTAL_MAX = 16'hFFFF;

   typedef enum logic {
      ST_IDLE,
      ST_UPDATE
   } fpr_state_type;

   typedef struct packed {
      logic shift;
      logic load;
   } cell_ctrl_type;

endpackage

@@ design/fpr_cell.sv @@
// One cell of the resident page row: holds a page and its frame, compares it
// against the looked-up page and takes its neighbor's entry on a shift.
// Depends on fpr_pkg.
`timescale 1ns / 1ps

module fpr_cell #(
   parameter int FRAME_W = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  fpr_pkg::cell_ctrl_type      ctrl,
   input  logic [fpr_pkg::PAGE_W-1:0]  lookup_page,
   input  logic [FRAME_W-1:0]          new_frame,
   input  logic                        nbr_occ,
   input  logic [fpr_pkg::PAGE_W-1:0]  nbr_page,
   input  logic [FRAME_W-1:0]          nbr_frame,
   output logic                        occ,
   output logic [fpr_pkg::PAGE_W-1:0]  page,
   output logic [FRAME_W-1:0]          frame,
   output logic                        match
);
   import fpr_pkg::*;

   logic               occ_ff, occ_in;
   logic [PAGE_W-1:0]  page_ff, page_in;
   logic [FRAME_W-1:0] frame_ff, frame_in;

   always_comb begin
      occ_in   = occ_ff;
      page_in  = page_ff;
      frame_in = frame_ff;
      if (ctrl.load) begin
         occ_in   = 1'b1;
         page_in  = lookup_page;
         frame_in = new_frame;
      end else if (ctrl.shift) begin
         occ_in   = nbr_occ;
         page_in  = nbr_page;
         frame_in = nbr_frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      page_ff  <= page_in;
      frame_ff <= frame_in;
   end

   assign occ   = occ_ff;
   assign page  = page_ff;
   assign frame = frame_ff;
   assign match = occ_ff && (page_ff == lookup_page);

endmodule

@@ design/fifo_page_replacement_core.sv @@
// Top level of the FIFO page replacement core: control, fault counter,
// result register and the row of resident page cells.
// Depends on fpr_pkg and fpr_cell.
`timescale 1ns / 1ps

// Each page reference passes two states, one to capture the page and one to
// compare it against every cell of the resident row at once and update the
// row, which holds the resident pages oldest first. A new reference is taken
// while the previous result still waits on the result channel. The frame
// count register may be written at any time the core is idle; zero acts as
// one and values above FRAME_COUNT act as FRAME_COUNT. There is no clearing
// pass after reset.
module fifo_page_replacement_core #(
   parameter int FRAME_COUNT = 16,
   localparam int FRAME_W = (FRAME_COUNT > 1) ? $clog2(FRAME_COUNT) : 1
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_valid,
   output logic                         csr_ready,
   input  logic [fpr_pkg::CFG_W-1:0]    csr_frames_in_use,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [fpr_pkg::PAGE_W-1:0]   req_page_number,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic                         rsp_fault,
   output logic [FRAME_W-1:0]           rsp_frame_index,
   output logic                         rsp_evicted_valid,
   output logic [fpr_pkg::PAGE_W-1:0]   rsp_evicted_page,
   output logic [fpr_pkg::TOTAL_W-1:0]  rsp_fault_total
);
   import fpr_pkg::*;

   localparam int CNT_W = $clog2(FRAME_COUNT + 1);
   localparam int CMP_W = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   fpr_state_type      state_ff, state_in;
   logic [CFG_W-1:0]   frames_in_use_ff;
   logic [PAGE_W-1:0]  page_ff;
   logic [CNT_W-1:0]   count_ff, count_in;
   logic [TOTAL_W-1:0] total_ff, total_in;

   logic               rsp_valid_ff, rsp_valid_in;
   logic               rsp_fault_ff;
   logic [FRAME_W-1:0] rsp_frame_ff;
   logic               rsp_ev_valid_ff;
   logic [PAGE_W-1:0]  rsp_ev_page_ff;
   logic [TOTAL_W-1:0] rsp_total_ff;

   logic [CMP_W-1:0]   cfg_ext;
   logic [CNT_W-1:0]   usable;
   logic               do_update;
   logic               hit, fill, evict;
   logic [FRAME_W-1:0] hit_frame, new_frame;
   logic [CNT_W-1:0]   target;

   logic [FRAME_COUNT-1:0] match_vec;
   logic [FRAME_COUNT-1:0] occ_vec;
   logic [PAGE_W-1:0]      page_vec  [FRAME_COUNT];
   logic [FRAME_W-1:0]     frame_vec [FRAME_COUNT];
   cell_ctrl_type          ctrl_vec  [FRAME_COUNT];

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         frames_in_use_ff <= CFG_RESET;
      end else if (csr_valid && csr_ready) begin
         frames_in_use_ff <= csr_frames_in_use;
      end
   end

   always_comb begin
      cfg_ext = CMP_W'(frames_in_use_ff);
      if (cfg_ext == '0) begin
         usable = CNT_W'(1);
      end else if (cfg_ext > CMP_W'(FRAME_COUNT)) begin
         usable = CNT_W'(FRAME_COUNT);
      end else begin
         usable = cfg_ext[CNT_W-1:0];
      end
   end

   genvar gi;
   generate
      for (gi = 0; gi < FRAME_COUNT; gi++) begin : g_cell
         logic               nbr_occ;
         logic [PAGE_W-1:0]  nbr_page;
         logic [FRAME_W-1:0] nbr_frame;

         if (gi == FRAME_COUNT - 1) begin : g_last
            assign nbr_occ   = 1'b0;
            assign nbr_page  = '0;
            assign nbr_frame = '0;
         end else begin : g_mid
            assign nbr_occ   = occ_vec[gi+1];
            assign nbr_page  = page_vec[gi+1];
            assign nbr_frame = frame_vec[gi+1];
         end

         assign ctrl_vec[gi].shift = do_update && evict;
         assign ctrl_vec[gi].load  = do_update && (fill || evict)
                                     && (target == CNT_W'(gi));

         fpr_cell #(
            .FRAME_W(FRAME_W)
         ) u_cell (
            .clock       (clock),
            .reset       (reset),
            .ctrl        (ctrl_vec[gi]),
            .lookup_page (page_ff),
            .new_frame   (new_frame),
            .nbr_occ     (nbr_occ),
            .nbr_page    (nbr_page),
            .nbr_frame   (nbr_frame),
            .occ         (occ_vec[gi]),
            .page        (page_vec[gi]),
            .frame       (frame_vec[gi]),
            .match       (match_vec[gi])
         );
      end
   endgenerate

   always_comb begin
      hit_frame = '0;
      for (int i = 0; i < FRAME_COUNT; i++) begin
         hit_frame = hit_frame | (frame_vec[i] & {FRAME_W{match_vec[i]}});
      end
   end

   assign hit       = |match_vec;
   assign fill      = !hit && (count_ff < usable);
   assign evict     = !hit && !fill;
   assign new_frame = fill ? count_ff[FRAME_W-1:0] : frame_vec[0];
   assign target    = fill ? count_ff : count_ff - CNT_W'(1);
   assign do_update = (state_ff == ST_UPDATE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      total_in     = total_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      req_ready    = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               state_in = ST_UPDATE;
            end
         end
         ST_UPDATE: begin
            if (do_update) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               if (fill) begin
                  count_in = count_ff + CNT_W'(1);
               end
               if (!hit && (total_ff != TOTAL_MAX)) begin
                  total_in = total_ff + TOTAL_W'(1);
               end
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         page_ff <= req_page_number;
      end
      if (do_update) begin
         rsp_fault_ff    <= !hit;
         rsp_frame_ff    <= hit ? hit_frame : new_frame;
         rsp_ev_valid_ff <= evict;
         rsp_ev_page_ff  <= evict ? page_vec[0] : '0;
         rsp_total_ff    <= total_in;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_fault         = rsp_fault_ff;
   assign rsp_frame_index   = rsp_frame_ff;
   assign rsp_evicted_valid = rsp_ev_valid_ff;
   assign rsp_evicted_page  = rsp_ev_page_ff;
   assign rsp_fault_total   = rsp_total_ff;

`ifndef ASSERT_OFF
   a_one_match: assert property (@(posedge clock) disable iff (reset)
      $onehot0(match_vec))
      else $error("A page is resident in more than one cell.");

   a_count_range: assert property (@(posedge clock) disable iff (reset)
      count_ff <= CNT_W'(FRAME_COUNT))
      else $error("The filled frame count exceeds the frame count.");

   a_accept_busy: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready)
      else $error("A word was taken while the previous one was still in work.");

   a_evict_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_evicted_valid |-> rsp_evicted_page == '0)
      else $error("An evicted page is reported without an eviction.");
`endif

endmodule

@@ tb/sv/fifo_page_replacement_core_tb.sv @@
// Self-checking testbench for fifo_page_replacement_core: a directed table, then random
// page streams under several frame counts, checked word by word against a local predictor.
// Depends on fpr_pkg and the core RTL.
`timescale 1ns / 1ps

module fifo_page_replacement_core_tb;
   import fpr_pkg::*;

   localparam int FRAME_BITS    = 4;
   localparam int DIRECTED_ROWS = 24;
   localparam int HOLD_CYCLES   = 400;

   typedef struct packed {
      logic                  fault;
      logic [FRAME_BITS-1:0] frame;
      logic                  ev_valid;
      logic [PAGE_W-1:0]     ev_page;
      logic [TOTAL_W-1:0]    total;
   } page_result_type;

   typedef struct packed {
      logic [PAGE_W-1:0] page;
      logic              typed;
      page_result_type   want;
   } directed_row_type;

   logic                  clock;
   logic                  reset;
   logic                  csr_valid;
   logic                  csr_ready;
   logic [CFG_W-1:0]      csr_frames_in_use;
   logic                  req_valid;
   logic                  req_ready;
   logic [PAGE_W-1:0]     req_page_number;
   logic                  rsp_valid;
   logic                  rsp_ready;
   logic                  rsp_fault;
   logic [FRAME_BITS-1:0] rsp_frame_index;
   logic                  rsp_evicted_valid;
   logic [PAGE_W-1:0]     rsp_evicted_page;
   logic [TOTAL_W-1:0]    rsp_fault_total;

   // Predictor state: page table, arrival order of resident pages and the fault count.
   bit                    resident [256];
   logic [FRAME_BITS-1:0] resident_frame [256];
   logic [PAGE_W-1:0]     arrival [16];
   logic [3:0]            arrival_head = '0;
   logic [4:0]            arrival_count = '0;
   logic [4:0]            filled_frames = '0;
   logic [TOTAL_W-1:0]    fault_count = '0;
   logic [CFG_W-1:0]      frame_limit = CFG_RESET;

   page_result_type  expected_results [$];
   directed_row_type directed_rows [DIRECTED_ROWS];
   int               mismatch_count = 0;
   bit               quiet = 1'b0;
   bit               hold_req = 1'b0;

   fifo_page_replacement_core dut (
      .clock             (clock),
      .reset             (reset),
      .csr_valid         (csr_valid),
      .csr_ready         (csr_ready),
      .csr_frames_in_use (csr_frames_in_use),
      .req_valid         (req_valid),
      .req_ready         (req_ready),
      .req_page_number   (req_page_number),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_fault         (rsp_fault),
      .rsp_frame_index   (rsp_frame_index),
      .rsp_evicted_valid (rsp_evicted_valid),
      .rsp_evicted_page  (rsp_evicted_page),
      .rsp_fault_total   (rsp_fault_total)
   );

   initial clock = 1'b0;
   always #4 clock = ~clock;

   initial begin
      #(20_000_000);
      $display("Regression FAIL");
      $finish;
   end

   function automatic page_result_type resolve_reference(input logic [PAGE_W-1:0] page);
      page_result_type   res;
      logic [4:0]        usable;
      logic [PAGE_W-1:0] victim;
      logic [3:0]        slot;
      res = '0;
      usable = (frame_limit == 0) ? 5'd1 : ((frame_limit > 16) ? 5'd16 : frame_limit);
      if (resident[page]) begin
         res.frame = resident_frame[page];
      end else begin
         res.fault = 1'b1;
         if (fault_count != TOTAL_MAX) fault_count = fault_count + 1'b1;
         if (filled_frames < usable) begin
            res.frame = filled_frames[3:0];
            filled_frames = filled_frames + 1'b1;
         end else if (arrival_count != 0) begin
            victim = arrival[arrival_head];
            arrival_head = arrival_head + 1'b1;
            arrival_count = arrival_count - 1'b1;
            res.frame = resident_frame[victim];
            resident[victim] = 1'b0;
            res.ev_valid = 1'b1;
            res.ev_page = victim;
         end
         resident[page] = 1'b1;
         resident_frame[page] = res.frame;
         if (arrival_count < 16) begin
            slot = arrival_head + arrival_count[3:0];
            arrival[slot] = page;
            arrival_count = arrival_count + 1'b1;
         end
      end
      res.total = fault_count;
      return res;
   endfunction

   task automatic send_reference(input logic [PAGE_W-1:0] page, input logic typed,
                                 input page_result_type want);
      page_result_type predicted;
      req_valid <= 1'b1;
      req_page_number <= page;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predicted = resolve_reference(page);
      expected_results.push_back(typed ? want : predicted);
   endtask

   task automatic sender_pause();
      if (!quiet && $urandom_range(0, 5) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 15)) @(posedge clock);
      end
   endtask

   task automatic drain_results();
      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_frames(input logic [CFG_W-1:0] value);
      csr_valid <= 1'b1;
      csr_frames_in_use <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      frame_limit = value;
   endtask

   task automatic run_phase(input logic [CFG_W-1:0] value, input int count, input bit burst);
      logic [PAGE_W-1:0] base;
      logic [PAGE_W-1:0] page;
      int                span;
      drain_results();
      write_frames(value);
      base = PAGE_W'($urandom_range(0, 255));
      span = ((value == 0) ? 1 : ((value > 16) ? 16 : value)) + $urandom_range(1, 6);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 9) < 7) page = base + PAGE_W'($urandom_range(0, span - 1));
         else page = PAGE_W'($urandom_range(0, 255));
         send_reference(page, 1'b0, '0);
         if (!burst) sender_pause();
      end
   endtask

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (want !== got) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
         mismatch_count++;
      end
   endtask

   always @(posedge clock) begin
      page_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (expected_results.size() == 0) begin
            $display("%0t: unexpected result word, expected none, actual fault %0d frame %0d",
                     $time, rsp_fault, rsp_frame_index);
            mismatch_count++;
         end else begin
            want = expected_results.pop_front();
            check_field("fault", want.fault, rsp_fault);
            check_field("frame_index", want.frame, rsp_frame_index);
            check_field("evicted_valid", want.ev_valid, rsp_evicted_valid);
            check_field("evicted_page", want.ev_page, rsp_evicted_page);
            check_field("fault_total", want.total, rsp_fault_total);
         end
      end
   end

   // The result side stalls in random bursts, and once holds off long enough to back up
   // the core.
   initial begin
      rsp_ready = 1'b0;
      while (reset !== 1'b0) @(posedge clock);
      forever begin
         @(posedge clock);
         if (hold_req) begin
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
            hold_req = 1'b0;
            rsp_ready <= 1'b1;
         end else if (!quiet && $urandom_range(0, 7) == 0) begin
            rsp_ready <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clock);
            rsp_ready <= 1'b1;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_page_number = '0;
      csr_valid = 1'b0;
      csr_frames_in_use = '0;
      // Fields: page, typed, fault, frame, evicted_valid, evicted_page, fault_total.
      directed_rows = '{
         {8'd0,   1'b1, 1'b1, 4'd0,  1'b0, 8'd0,   16'd1},
         {8'd255, 1'b1, 1'b1, 4'd1,  1'b0, 8'd0,   16'd2},
         {8'd0,   1'b1, 1'b0, 4'd0,  1'b0, 8'd0,   16'd2},
         {8'd255, 1'b1, 1'b0, 4'd1,  1'b0, 8'd0,   16'd2},
         {8'd1,   1'b1, 1'b1, 4'd2,  1'b0, 8'd0,   16'd3},
         {8'd2,   1'b1, 1'b1, 4'd3,  1'b0, 8'd0,   16'd4},
         {8'd3,   1'b1, 1'b1, 4'd4,  1'b0, 8'd0,   16'd5},
         {8'd4,   1'b1, 1'b1, 4'd5,  1'b0, 8'd0,   16'd6},
         {8'd5,   1'b1, 1'b1, 4'd6,  1'b0, 8'd0,   16'd7},
         {8'd6,   1'b1, 1'b1, 4'd7,  1'b0, 8'd0,   16'd8},
         {8'd7,   1'b1, 1'b1, 4'd8,  1'b0, 8'd0,   16'd9},
         {8'd8,   1'b1, 1'b1, 4'd9,  1'b0, 8'd0,   16'd10},
         {8'd9,   1'b1, 1'b1, 4'd10, 1'b0, 8'd0,   16'd11},
         {8'd10,  1'b1, 1'b1, 4'd11, 1'b0, 8'd0,   16'd12},
         {8'd11,  1'b1, 1'b1, 4'd12, 1'b0, 8'd0,   16'd13},
         {8'd12,  1'b1, 1'b1, 4'd13, 1'b0, 8'd0,   16'd14},
         {8'd13,  1'b1, 1'b1, 4'd14, 1'b0, 8'd0,   16'd15},
         {8'd14,  1'b1, 1'b1, 4'd15, 1'b0, 8'd0,   16'd16},
         {8'd128, 1'b1, 1'b1, 4'd0,  1'b1, 8'd0,   16'd17},
         {8'd0,   1'b1, 1'b1, 4'd1,  1'b1, 8'd255, 16'd18},
         {8'd255, 1'b1, 1'b1, 4'd2,  1'b1, 8'd1,   16'd19},
         {8'd128, 1'b1, 1'b0, 4'd0,  1'b0, 8'd0,   16'd19},
         {8'd170, 1'b0, 30'd0},
         {8'd85,  1'b0, 30'd0}
      };
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      for (int i = 0; i < DIRECTED_ROWS; i++) begin
         send_reference(directed_rows[i].page, directed_rows[i].typed, directed_rows[i].want);
         sender_pause();
      end

      // All sixteen frames are filled here, so lowering the count forces evictions.
      run_phase(5'd4, 200, 1'b0);
      run_phase(5'd0, 200, 1'b0);
      run_phase(5'd31, 200, 1'b0);
      run_phase(5'd17, 200, 1'b0);
      run_phase(5'd1, 200, 1'b0);
      drain_results();
      hold_req = 1'b1;
      run_phase(5'd16, 40, 1'b1);
      run_phase(5'd16, 200, 1'b0);
      run_phase(5'd2, 200, 1'b0);
      run_phase(5'd9, 200, 1'b0);
      run_phase(5'd15, 150, 1'b0);

      // The closing phase runs with no idling on either side.
      quiet = 1'b1;
      run_phase(5'd1, 136, 1'b1);

      req_valid <= 1'b0;
      while (expected_results.size() != 0) @(posedge clock);
      repeat (10) @(posedge clock);
      if (mismatch_count == 0) $display("Regression PASS");
      else $display("Regression FAIL");
      $finish;
   end

endmodule
